// ===== rtl/core/esrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine sound player package
// Shared widths, codes, reset values and types of the rpm playback block.
// ----------------------------------------------------------------------------
package esrp_pkg;

    localparam int ACT_W      = 2;
    localparam int THR_W      = 10;
    localparam int LIDX_W     = 12;
    localparam int SAMP_W     = 8;
    localparam int RPM_W      = 14;
    localparam int PERIOD_W   = 16;
    localparam int BASE_W     = 16;
    localparam int MULT_W     = 16;
    localparam int LEN_CFG_W  = 13;
    localparam int STEP_W     = 8;
    localparam int PROD_W     = RPM_W + MULT_W;
    localparam int DEN_W      = BASE_W + 1 + (PROD_W - 8) - BASE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - SAMP_W - RPM_W - PERIOD_W;
    localparam int IN_PAD_W   = IN_DATA_W - THR_W - 1 - LIDX_W - SAMP_W;
    localparam int Q_DEPTH    = 2;

    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CTRL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RATE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MULT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM     = 3'd5;

    localparam int BASE_RATE_RST = 22050;
    localparam logic [BASE_W-1:0]    RST_BASE_RATE  = 16'd22050;
    localparam logic [MULT_W-1:0]    RST_SPEED_MULT = 16'd256;
    localparam logic [LEN_CFG_W-1:0] RST_SAMPLE_LEN = 13'd4096;
    localparam logic [STEP_W-1:0]    RST_RISE_STEP  = 8'd18;
    localparam logic [STEP_W-1:0]    RST_FALL_STEP  = 8'd12;
    localparam logic [RPM_W-1:0]     RST_MAX_RPM    = 14'd8184;

    localparam logic [SAMP_W-1:0]   LEVEL_OFF  = 8'hFF;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_CTRL,
        KIND_LOAD,
        KIND_NONE
    } t_kind;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_MUL,
        BS_DEN,
        BS_DIV
    } t_bstate;

    typedef struct packed {
        logic [BASE_W-1:0]    base_rate;
        logic [MULT_W-1:0]    speed_mult;
        logic [LEN_CFG_W-1:0] sample_length;
        logic [STEP_W-1:0]    rise_step;
        logic [STEP_W-1:0]    fall_step;
        logic [RPM_W-1:0]     max_rpm;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic [THR_W-1:0]   throttle;
        logic               engine_on;
        logic [LIDX_W-1:0]  load_index;
        logic [SAMP_W-1:0]  load_value;
    } t_item;

    typedef struct packed {
        logic busy;
        logic div_busy;
    } t_back_stat;

endpackage

// ===== rtl/core/esrp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module esrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/esrp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine sound player front end
// Accepts input transfers, decodes the action into a kind and queues items.
// ----------------------------------------------------------------------------
module esrp_front import esrp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [ACT_W-1:0]     s_axis_tuser,
    output logic                 o_q_valid,
    output t_item                o_q_item,
    input  logic                 i_q_pop
);

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_item            r_buf [Q_DEPTH];
    logic [QP_W-1:0]  r_wp, n_wp;
    logic [QP_W-1:0]  r_rp, n_rp;
    logic [QC_W-1:0]  r_cnt, n_cnt;
    t_item            w_item;
    logic             w_push;

    always_comb begin
        w_item.throttle   = s_axis_tdata[THR_W-1:0];
        w_item.engine_on  = s_axis_tdata[THR_W];
        w_item.load_index = s_axis_tdata[THR_W+1+:LIDX_W];
        w_item.load_value = s_axis_tdata[THR_W+1+LIDX_W+:SAMP_W];
        case (s_axis_tuser)
            ACT_TICK: w_item.kind = KIND_TICK;
            ACT_CTRL: w_item.kind = KIND_CTRL;
            ACT_LOAD: w_item.kind = KIND_LOAD;
            default:  w_item.kind = KIND_NONE;
        endcase
    end

    assign s_axis_tready = (r_cnt != QC_W'(Q_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != '0);
    assign o_q_item      = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == QP_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_q_pop) begin
            n_rp = (r_rp == QP_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (w_push && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_item;
        end
    end

endmodule

// ===== rtl/core/esrp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Period divider
// Bit-serial restoring division of the clock rate by the sample rate,
// one quotient bit per cycle, result saturated to the period width.
// ----------------------------------------------------------------------------
module esrp_div import esrp_pkg::*; #(
    parameter int CLOCK_HZ = 16000000
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DEN_W-1:0]    i_den,
    output logic                o_busy,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_quot
);

    localparam int DIV_W = $clog2(CLOCK_HZ + 1);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_rem_nx;
    logic             w_ge;
    logic             w_step;

    assign w_step   = r_busy && (r_cnt != '0);
    assign w_rem_sh = {r_rem, r_num[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= DIV_W'(CLOCK_HZ);
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= '0;
        end else if (w_step) begin
            r_num <= {r_num[DIV_W-2:0], 1'b0};
            r_rem <= w_rem_nx[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = (|r_quo[DIV_W-1:PERIOD_W]) ? PERIOD_MAX : r_quo[PERIOD_W-1:0];

endmodule

// ===== rtl/core/esrp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine sound player back end
// Executes queued items: timer and sample playback, rpm update with period
// recompute, table loads. Holds the result register.
// ----------------------------------------------------------------------------
module esrp_back import esrp_pkg::*; #(
    parameter int TABLE_DEPTH = 4096,
    parameter int CLOCK_HZ    = 16000000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic                  i_q_valid,
    input  t_item                 i_q_item,
    output logic                  o_q_pop,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic                  o_m_tuser,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output t_back_stat            o_stat
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int IDX_W   = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W   = (IDX_W > LEN_CFG_W) ? IDX_W : LEN_CFG_W;
    localparam int LEXT_W  = ADDR_W + LIDX_W;
    localparam int RAW_PER = CLOCK_HZ / BASE_RATE_RST;
    localparam int RST_PER = (RAW_PER > 65535) ? 65535 : RAW_PER;

    t_bstate             r_state, n_state;
    logic [RPM_W-1:0]    r_rpm, n_rpm;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [PERIOD_W-1:0] r_compare, n_compare;
    logic [PERIOD_W-1:0] r_timer, n_timer;
    logic [IDX_W-1:0]    r_sidx, n_sidx;
    logic [SAMP_W-1:0]   r_level, n_level;
    logic                r_out_valid, n_out_valid;
    logic                r_out_flag, n_out_flag;
    logic [PROD_W-1:0]   r_prod, n_prod;

    logic                w_out_free;
    logic [IDX_W-1:0]    w_idx_base;
    logic [IDX_W-1:0]    w_idx;
    logic [LEN_W-1:0]    w_len_full;
    logic [IDX_W-1:0]    w_len;
    logic [LEXT_W-1:0]   w_lidx_ext;
    logic [RPM_W:0]      w_up;
    logic [RPM_W:0]      w_thr_rise;
    logic [RPM_W-1:0]    w_rpm_nx;
    logic [DEN_W-1:0]    w_den;

    logic                w_ram_we;
    logic                w_ram_re;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic [ADDR_W-1:0]   w_ram_raddr;
    logic [SAMP_W-1:0]   w_ram_rdata;

    logic                w_div_start;
    logic                w_div_busy;
    logic                w_div_done;
    logic [PERIOD_W-1:0] w_div_quot;

    esrp_ram #(
        .WIDTH (SAMP_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (i_q_item.load_value),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    esrp_div #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_idx_base = i_q_item.engine_on ? r_sidx : '0;
    assign w_len_full = LEN_W'(i_cfg.sample_length);
    assign w_len      = (w_len_full > LEN_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH)
                                                           : w_len_full[IDX_W-1:0];
    assign w_idx       = (w_idx_base >= w_len) ? '0 : w_idx_base;
    assign w_ram_raddr = w_idx[ADDR_W-1:0];
    assign w_lidx_ext  = LEXT_W'(i_q_item.load_index);
    assign w_ram_waddr = w_lidx_ext[ADDR_W-1:0];
    assign w_den       = DEN_W'(i_cfg.base_rate) + DEN_W'(r_prod[PROD_W-1:8]);

    // rpm moves toward the throttle, capped on the way up, floored at zero
    assign w_thr_rise = (RPM_W + 1)'(i_q_item.throttle) + (RPM_W + 1)'(i_cfg.rise_step);
    assign w_up       = (RPM_W + 1)'(r_rpm) + (RPM_W + 1)'(i_cfg.rise_step);
    always_comb begin
        if (w_thr_rise > (RPM_W + 1)'(r_rpm)) begin
            w_rpm_nx = (w_up > (RPM_W + 1)'(i_cfg.max_rpm)) ? i_cfg.max_rpm
                                                            : w_up[RPM_W-1:0];
        end else if (r_rpm > RPM_W'(i_cfg.fall_step)) begin
            w_rpm_nx = r_rpm - RPM_W'(i_cfg.fall_step);
        end else begin
            w_rpm_nx = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rpm       = r_rpm;
        n_period    = r_period;
        n_compare   = r_compare;
        n_timer     = r_timer;
        n_sidx      = r_sidx;
        n_level     = r_level;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_flag  = r_out_flag;
        o_q_pop     = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    n_sidx  = w_idx_base;
                    case (i_q_item.kind)
                        KIND_TICK: begin
                            if (r_timer == r_compare) begin
                                n_timer   = '0;
                                n_compare = r_period;
                                if (i_q_item.engine_on) begin
                                    w_ram_re = 1'b1;
                                    n_sidx   = w_idx + 1'b1;
                                    n_state  = BS_READ;
                                end else begin
                                    n_level     = LEVEL_OFF;
                                    n_out_valid = 1'b1;
                                    n_out_flag  = 1'b1;
                                end
                            end else begin
                                n_timer     = r_timer + 1'b1;
                                n_out_valid = 1'b1;
                                n_out_flag  = 1'b0;
                            end
                        end
                        KIND_CTRL: begin
                            n_rpm   = w_rpm_nx;
                            n_state = BS_MUL;
                        end
                        KIND_LOAD: begin
                            w_ram_we    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_flag  = 1'b0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_flag  = 1'b0;
                        end
                    endcase
                end
            end
            BS_READ: begin
                n_level     = w_ram_rdata;
                n_out_valid = 1'b1;
                n_out_flag  = 1'b1;
                n_state     = BS_IDLE;
            end
            BS_MUL: begin
                n_prod  = PROD_W'(r_rpm) * PROD_W'(i_cfg.speed_mult);
                n_state = BS_DEN;
            end
            BS_DEN: begin
                w_div_start = 1'b1;
                n_state     = BS_DIV;
            end
            BS_DIV: begin
                if (w_div_done) begin
                    n_period    = w_div_quot;
                    n_out_valid = 1'b1;
                    n_out_flag  = 1'b0;
                    n_state     = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_rpm       <= '0;
            r_period    <= PERIOD_W'(RST_PER);
            r_compare   <= PERIOD_W'(RST_PER);
            r_timer     <= '0;
            r_sidx      <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
            r_out_flag  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rpm       <= n_rpm;
            r_period    <= n_period;
            r_compare   <= n_compare;
            r_timer     <= n_timer;
            r_sidx      <= n_sidx;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            r_out_flag  <= n_out_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_m_tuser       = r_out_flag;
    assign o_m_tdata       = {{OUT_PAD_W{1'b0}}, r_period, r_rpm, r_level};
    assign o_stat.busy     = (r_state != BS_IDLE);
    assign o_stat.div_busy = w_div_busy;

endmodule

// ===== rtl/core/engine_sound_rpm_playback.sv =====
`timescale 1ns / 1ps
// A clock tick, load or unused action passes through the queue and the result register;
// a clock tick that hits the compare value with the engine on also goes through the table
// RAM read. A control tick passes through the multiply, divisor and bit-serial period
// divider states. Throughput: one item per cycle for ticks without a match while the
// output is not stalled. Reset is synchronous, active low; the sample table is not cleared.
// ----------------------------------------------------------------------------
// Engine sound rpm playback
// Simulated engine rpm follows the throttle, sets the playback period and
// steps through a loaded sample table on timer matches.
// ----------------------------------------------------------------------------
module engine_sound_rpm_playback import esrp_pkg::*; #(
    parameter int TABLE_DEPTH = 4096,
    parameter int CLOCK_HZ    = 16000000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // throttle[9:0], engine_on[10], load_index[22:11], load_value[30:23], zero[31]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pwm_level[7:0], rpm_now[21:8], sample_period[37:22], zero[39:38]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // sample_valid[0]
    output logic                  m_axis_tuser
);

    t_cfg       r_cfg;
    logic       w_q_valid;
    t_item      w_q_item;
    logic       w_q_pop;
    t_back_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_rate     <= RST_BASE_RATE;
            r_cfg.speed_mult    <= RST_SPEED_MULT;
            r_cfg.sample_length <= RST_SAMPLE_LEN;
            r_cfg.rise_step     <= RST_RISE_STEP;
            r_cfg.fall_step     <= RST_FALL_STEP;
            r_cfg.max_rpm       <= RST_MAX_RPM;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BASE_RATE:  r_cfg.base_rate     <= i_cfg_data[BASE_W-1:0];
                CFG_SPEED_MULT: r_cfg.speed_mult    <= i_cfg_data[MULT_W-1:0];
                CFG_SAMPLE_LEN: r_cfg.sample_length <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_RISE_STEP:  r_cfg.rise_step     <= i_cfg_data[STEP_W-1:0];
                CFG_FALL_STEP:  r_cfg.fall_step     <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_RPM:    r_cfg.max_rpm       <= i_cfg_data[RPM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    esrp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    esrp_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CLOCK_HZ    (CLOCK_HZ)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tdata  (m_axis_tdata),
        .o_stat     (w_stat)
    );

`ifndef ASSERT_OFF
    a_busy_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !m_axis_tvalid)
        else $error("back end busy while a result is pending");

    a_div_in_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_busy |-> w_stat.busy)
        else $error("divider running outside an rpm update");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> (w_q_valid && !w_stat.busy))
        else $error("queue popped while empty or back end busy");
`endif

endmodule

// ===== bench/tb_engine_sound_rpm_playback.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine sound rpm playback testbench
// Sends tick, control, load and unused items over the input stream and
// predicts each result: rpm stepping, period division with saturation, timer
// matches, table playback, loop wrap and silent rewind. Checks every result
// field against the prediction. Runs several register settings, from the
// extremes to typical values, with random gaps and one long output stall.
// ----------------------------------------------------------------------------
module tb_engine_sound_rpm_playback;
    import esrp_pkg::*;

    localparam int TBL_DEPTH   = 4096;
    localparam int CLK_RATE_HZ = 16000000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_GAP    = 4;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic                valid;
        logic [SAMP_W-1:0]   level;
        logic [RPM_W-1:0]    rpm;
        logic [PERIOD_W-1:0] period;
    } t_playback;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // throttle[9:0], engine_on[10], load_index[22:11], load_value[30:23], zero[31]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // action[1:0]
    logic [ACT_W-1:0]      s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // pwm_level[7:0], rpm_now[21:8], sample_period[37:22], zero[39:38]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // sample_valid[0]
    logic                  m_axis_tuser;

    // engine state as predicted
    t_cfg                eng_cfg;
    logic [RPM_W-1:0]    eng_rpm;
    logic [PERIOD_W-1:0] eng_period;
    logic [PERIOD_W-1:0] eng_compare;
    logic [PERIOD_W-1:0] eng_timer;
    int unsigned         eng_index;
    logic [SAMP_W-1:0]   eng_level;
    logic [SAMP_W-1:0]   eng_table [TBL_DEPTH];

    // stimulus bookkeeping: which table prefix is loaded, bound on the play index
    bit          gen_loaded [TBL_DEPTH];
    int unsigned gen_filled = 0;
    int unsigned gen_idx_hi = 0;
    int unsigned gen_len = TBL_DEPTH;

    t_item     engine_items [$];
    t_playback playback_due [$];
    t_item     in_flight;
    t_playback fresh_due;
    t_playback seen;
    t_playback want;

    int src_gap_max = 15;
    int snk_gap_max = 15;
    int src_wait = 0;
    int snk_wait = 0;
    int gap_draw;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int err_cnt = 0;
    int cycle_cnt = 0;
    int n_in = 0;
    int n_out = 0;
    int n_ctrl = 0;
    int n_load = 0;
    int n_match = 0;
    int n_silent = 0;

    engine_sound_rpm_playback #(
        .TABLE_DEPTH (TBL_DEPTH),
        .CLOCK_HZ    (CLK_RATE_HZ)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PERIOD_W-1:0] period_for(input logic [RPM_W-1:0] r);
        logic [31:0] den;
        logic [31:0] quo;
        den = 32'(eng_cfg.base_rate) + ((32'(r) * 32'(eng_cfg.speed_mult)) >> 8);
        if (den == 0) return PERIOD_MAX;
        quo = 32'(CLK_RATE_HZ) / den;
        return (quo > 32'(PERIOD_MAX)) ? PERIOD_MAX : quo[PERIOD_W-1:0];
    endfunction

    task automatic engine_step(input t_item it, output t_playback res);
        int unsigned lim;
        logic [31:0] sum;
        res.valid = 1'b0;
        if (!it.engine_on) eng_index = 0;
        case (it.kind)
            KIND_TICK: begin
                if (eng_timer == eng_compare) begin
                    lim = (eng_cfg.sample_length > TBL_DEPTH) ? TBL_DEPTH : eng_cfg.sample_length;
                    eng_timer = '0;
                    eng_compare = eng_period;
                    if (eng_index >= lim) eng_index = 0;
                    if (it.engine_on) begin
                        eng_level = eng_table[eng_index % TBL_DEPTH];
                        eng_index++;
                    end else begin
                        eng_level = LEVEL_OFF;
                    end
                    res.valid = 1'b1;
                end else begin
                    eng_timer = eng_timer + 1'b1;
                end
            end
            KIND_CTRL: begin
                if (32'(it.throttle) + 32'(eng_cfg.rise_step) > 32'(eng_rpm)) begin
                    sum = 32'(eng_rpm) + 32'(eng_cfg.rise_step);
                    eng_rpm = (sum > 32'(eng_cfg.max_rpm)) ? eng_cfg.max_rpm : RPM_W'(sum);
                end else if (eng_rpm > RPM_W'(eng_cfg.fall_step)) begin
                    eng_rpm = eng_rpm - RPM_W'(eng_cfg.fall_step);
                end else begin
                    eng_rpm = '0;
                end
                eng_period = period_for(eng_rpm);
            end
            KIND_LOAD: eng_table[it.load_index] = it.load_value;
            default: ;
        endcase
        res.level = eng_level;
        res.rpm = eng_rpm;
        res.period = eng_period;
    endtask

    function automatic void check_field(input string what, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                engine_step(in_flight, fresh_due);
                playback_due.push_back(fresh_due);
                n_in++;
                if (in_flight.kind == KIND_CTRL) n_ctrl++;
                if (in_flight.kind == KIND_LOAD) n_load++;
                if (fresh_due.valid) n_match++;
                if (fresh_due.valid && !in_flight.engine_on) n_silent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait != 0) begin
                    src_wait <= src_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (engine_items.size() != 0) begin
                    in_flight = engine_items.pop_front();
                    s_axis_tdata <= {1'b0, in_flight.load_value, in_flight.load_index,
                                     in_flight.engine_on, in_flight.throttle};
                    s_axis_tuser <= in_flight.kind;
                    s_axis_tvalid <= 1'b1;
                    src_wait <= $urandom_range(0, src_gap_max);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait <= 0;
            hold_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.valid = m_axis_tuser;
                seen.level = m_axis_tdata[7:0];
                seen.rpm = m_axis_tdata[21:8];
                seen.period = m_axis_tdata[37:22];
                n_out++;
                if (playback_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, seen);
                    err_cnt++;
                end else begin
                    want = playback_due.pop_front();
                    check_field("sample_valid", want.valid, seen.valid);
                    check_field("pwm_level", want.level, seen.level);
                    check_field("rpm_now", want.rpm, seen.rpm);
                    check_field("sample_period", want.period, seen.period);
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                gap_draw = $urandom_range(0, snk_gap_max);
                if (gap_draw != 0) begin
                    snk_wait <= gap_draw - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end else if (snk_wait != 0) begin
                snk_wait <= snk_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, CYCLE_LIMIT, playback_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // force the engine off on a tick that might read an unloaded table entry
    task automatic push_item(input t_kind kind, input logic [THR_W-1:0] thr, input bit want_on,
                             input logic [LIDX_W-1:0] lidx, input logic [SAMP_W-1:0] lval);
        t_item       it;
        int unsigned lim;
        it.kind = kind;
        it.throttle = thr;
        it.engine_on = want_on;
        it.load_index = lidx;
        it.load_value = lval;
        if (kind == KIND_TICK && want_on) begin
            lim = (gen_len == 0) ? 0 : gen_len - 1;
            if (((gen_idx_hi < lim) ? gen_idx_hi : lim) >= gen_filled) it.engine_on = 1'b0;
        end
        if (!it.engine_on) gen_idx_hi = 0;
        else if (kind == KIND_TICK) gen_idx_hi++;
        if (kind == KIND_LOAD) begin
            gen_loaded[lidx] = 1'b1;
            while (gen_filled < TBL_DEPTH && gen_loaded[gen_filled]) gen_filled++;
        end
        engine_items.push_back(it);
    endtask

    task automatic gen_random(input int n, input int tick_pct);
        int unsigned      pick;
        t_kind            kind;
        logic [THR_W-1:0] thr;
        logic [LIDX_W-1:0] lidx;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < tick_pct) begin
                kind = KIND_TICK;
            end else begin
                pick = $urandom_range(0, 5);
                kind = (pick < 3) ? KIND_CTRL : (pick < 5) ? KIND_LOAD : KIND_NONE;
            end
            thr = ($urandom_range(0, 1) != 0) ? THR_W'($urandom)
                                               : THR_W'($urandom_range(600, 1023));
            lidx = ($urandom_range(0, 1) != 0 && gen_filled < TBL_DEPTH) ? LIDX_W'(gen_filled)
                                                                         : LIDX_W'($urandom);
            push_item(kind, thr, $urandom_range(0, 99) < 85, lidx, SAMP_W'($urandom));
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_BASE_RATE:  eng_cfg.base_rate = val;
            CFG_SPEED_MULT: eng_cfg.speed_mult = val;
            CFG_SAMPLE_LEN: begin
                eng_cfg.sample_length = val[LEN_CFG_W-1:0];
                gen_len = (val[LEN_CFG_W-1:0] > TBL_DEPTH) ? TBL_DEPTH : val[LEN_CFG_W-1:0];
            end
            CFG_RISE_STEP:  eng_cfg.rise_step = val[STEP_W-1:0];
            CFG_FALL_STEP:  eng_cfg.fall_step = val[STEP_W-1:0];
            CFG_MAX_RPM:    eng_cfg.max_rpm = val[RPM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input int base, input int mult, input int len, input int rise,
                            input int fall, input int top);
        cfg_write(CFG_BASE_RATE, base);
        cfg_write(CFG_SPEED_MULT, mult);
        cfg_write(CFG_SAMPLE_LEN, len);
        cfg_write(CFG_RISE_STEP, rise);
        cfg_write(CFG_FALL_STEP, fall);
        cfg_write(CFG_MAX_RPM, top);
    endtask

    task automatic wait_idle;
        while (engine_items.size() != 0 || s_axis_tvalid || playback_due.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    // raise the rpm so that the period is short before any tick
    task automatic spin_up(input int n);
        for (int k = 0; k < n; k++) push_item(KIND_CTRL, '1, 1'b1, '0, '0);
    endtask

    initial begin
        eng_cfg.base_rate = RST_BASE_RATE;
        eng_cfg.speed_mult = RST_SPEED_MULT;
        eng_cfg.sample_length = RST_SAMPLE_LEN;
        eng_cfg.rise_step = RST_RISE_STEP;
        eng_cfg.fall_step = RST_FALL_STEP;
        eng_cfg.max_rpm = RST_MAX_RPM;
        eng_rpm = '0;
        eng_period = period_for('0);
        eng_compare = eng_period;
        eng_timer = '0;
        eng_index = 0;
        eng_level = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(KIND_LOAD, '0, 1'b1, '0, '0);
        push_item(KIND_LOAD, '1, 1'b0, '1, '1);
        for (int k = 1; k < 16; k++)
            push_item(KIND_LOAD, THR_W'($urandom), 1'b1, LIDX_W'(k), SAMP_W'($urandom));
        push_item(KIND_CTRL, '1, 1'b1, '0, '0);
        push_item(KIND_CTRL, '1, 1'b1, '0, '0);
        push_item(KIND_CTRL, '0, 1'b1, '1, '1);
        push_item(KIND_NONE, '0, 1'b1, '0, '0);
        push_item(KIND_NONE, '1, 1'b0, '1, '1);
        push_item(KIND_TICK, '0, 1'b1, '0, '0);
        push_item(KIND_TICK, '1, 1'b0, '1, '1);
        wait_idle();

        for (int k = 16; k < 64; k++)
            push_item(KIND_LOAD, THR_W'($urandom), $urandom_range(0, 1) != 0,
                      LIDX_W'(k), SAMP_W'($urandom));
        gen_random(800, 93);
        wait_idle();

        // short period, fast matches, long output stall
        set_mode(16'hFFFF, 16'hFFFF, 16, 255, 255, 16383);
        cfg_write(3'd6, 16'h1234);
        cfg_write(3'd7, 16'hFFFF);
        src_gap_max = 0;
        snk_gap_max = 0;
        hold_req = 1'b1;
        spin_up(4);
        gen_random(250, 80);
        wait_idle();

        // saturated and zero-divisor periods: no ticks, so the compare stays short
        set_mode(1, 0, 1, 0, 0, 0);
        src_gap_max = 15;
        snk_gap_max = 15;
        push_item(KIND_CTRL, '1, 1'b1, '0, '0);
        push_item(KIND_CTRL, '0, 1'b1, '0, '0);
        gen_random(20, 0);
        wait_idle();
        cfg_write(CFG_BASE_RATE, 0);
        gen_random(20, 0);
        wait_idle();

        set_mode(30000, 16'hFFFF, 1, 255, 0, 700);
        spin_up(3);
        gen_random(80, 75);
        wait_idle();

        set_mode(16'hFFFF, 0, 0, 128, 1, 1023);
        src_gap_max = 15;
        snk_gap_max = 0;
        spin_up(2);
        gen_random(100, 80);
        wait_idle();

        set_mode(16'hFFFF, 16'hFFFF, 8191, 18, 12, 8184);
        src_gap_max = 0;
        snk_gap_max = 15;
        spin_up(4);
        gen_random(80, 75);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d transfers in and %0d out, %0d timer matches (%0d while silent)",
                 n_in, n_out, n_match, n_silent);
        $display("with %0d control ticks and %0d table loads over seven register settings",
                 n_ctrl, n_load);
        if (err_cnt == 0 && playback_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
